FILE: rtl/easl_pkg.sv
// shared types and constants for the alert latch and siren controller
package easl_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int DEBOUNCE_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] TIMEOUT_RESET = 32'd300000;
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;
    localparam logic [1:0] ACT_ACK = 2'd3;

    localparam logic [3:0] TYPE_EMERGENCY = 4'd0;
    localparam logic [3:0] MIN_FRAME_LEN = 4'd8;
    localparam logic [3:0] STATE_ACTIVE_MAX = 4'd2;
    localparam logic [3:0] STATE_CLEAR_MIN = 4'd5;

    localparam logic RESP_SILENCE = 1'b0;
    localparam logic RESP_ACK = 1'b1;

    localparam logic BUTTON_RELEASED = 1'b1;
    localparam logic BUTTON_PRESSED = 1'b0;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] frame_length;
        logic [7:0] type_byte;
        logic [7:0] system_byte;
        logic [7:0] alert_id_low;
        logic [7:0] alert_id_high;
        logic [7:0] state_byte;
        logic [7:0] source_addr;
        logic       button_level;
    } in_item_t;

    typedef struct packed {
        logic        siren;
        logic        alert_flag;
        logic        resp_valid;
        logic        resp_code;
        logic [7:0]  resp_dest;
        logic [7:0]  resp_system;
        logic [15:0] resp_alert_id;
    } out_item_t;

endpackage

FILE: rtl/easl_core.sv
// alert latch state, config registers and per-item next-state logic
module easl_core #(
    parameter int TIME_BITS = easl_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [easl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [easl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 step,
    input  easl_pkg::in_item_t                   item,
    output easl_pkg::out_item_t                  result
);
    import easl_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > CFG_DATA_BITS) ? TIME_BITS : CFG_DATA_BITS;

    logic [CFG_DATA_BITS-1:0] timeout_reg;
    logic [DEBOUNCE_BITS-1:0] debounce_reg;

    logic [TIME_BITS-1:0] time_now_reg, time_now_next;
    logic [TIME_BITS-1:0] last_sample_reg, last_sample_next;
    logic [TIME_BITS-1:0] start_time_reg, start_time_next;
    logic                 button_prev_reg, button_prev_next;
    logic                 siren_reg, siren_next;
    logic                 alert_reg, alert_next;
    logic [15:0]          latched_id_reg, latched_id_next;
    logic [7:0]           latched_source_reg, latched_source_next;
    logic [7:0]           latched_system_reg, latched_system_next;

    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] sample_diff;
    logic [TIME_BITS-1:0] run_diff;
    logic                 sample_due;
    logic                 timed_out;
    logic [3:0]           frame_type;
    logic [3:0]           frame_state;
    logic [15:0]          frame_id;
    logic                 resp_valid;
    logic                 resp_code;

    assign time_inc    = time_now_reg + TIME_BITS'(1);
    assign sample_diff = time_inc - last_sample_reg;
    assign run_diff    = time_inc - start_time_reg;
    assign sample_due  = CMP_BITS'(sample_diff) >= CMP_BITS'(debounce_reg);
    assign timed_out   = CMP_BITS'(run_diff) >= CMP_BITS'(timeout_reg);
    assign frame_type  = item.type_byte[3:0];
    assign frame_state = item.state_byte[3:0];
    assign frame_id    = {item.alert_id_high, item.alert_id_low};

    always_comb
    begin
        time_now_next       = time_now_reg;
        last_sample_next    = last_sample_reg;
        start_time_next     = start_time_reg;
        button_prev_next    = button_prev_reg;
        siren_next          = siren_reg;
        alert_next          = alert_reg;
        latched_id_next     = latched_id_reg;
        latched_source_next = latched_source_reg;
        latched_system_next = latched_system_reg;
        resp_valid          = 1'b0;
        resp_code           = RESP_SILENCE;

        unique case (item.action)
            ACT_FRAME:
            begin
                if (item.frame_length >= MIN_FRAME_LEN && frame_type == TYPE_EMERGENCY)
                begin
                    if (frame_state <= STATE_ACTIVE_MAX)
                    begin
                        latched_id_next     = frame_id;
                        latched_source_next = item.source_addr;
                        latched_system_next = item.system_byte;
                        alert_next          = 1'b1;
                        siren_next          = 1'b1;
                        if (!siren_reg)
                        begin
                            start_time_next = time_now_reg;
                        end
                    end
                    else if (frame_state >= STATE_CLEAR_MIN && alert_reg
                             && frame_id == latched_id_reg
                             && item.source_addr == latched_source_reg)
                    begin
                        alert_next = 1'b0;
                        siren_next = 1'b0;
                    end
                end
            end
            ACT_TICK:
            begin
                time_now_next = time_inc;
                if (sample_due)
                begin
                    last_sample_next = time_inc;
                    if (button_prev_reg == BUTTON_RELEASED
                        && item.button_level == BUTTON_PRESSED && siren_reg)
                    begin
                        resp_valid = alert_reg;
                        siren_next = 1'b0;
                    end
                    button_prev_next = item.button_level;
                end
                // timeout only matters if the siren is still on after the button
                if (siren_next && timed_out)
                begin
                    siren_next = 1'b0;
                end
            end
            ACT_SILENCE:
            begin
                if (siren_reg)
                begin
                    resp_valid = alert_reg;
                    siren_next = 1'b0;
                end
            end
            ACT_ACK:
            begin
                if (alert_reg)
                begin
                    resp_valid = 1'b1;
                    resp_code  = RESP_ACK;
                    siren_next = 1'b0;
                    alert_next = 1'b0;
                end
            end
            default:
            begin
                time_now_next = time_now_reg;
            end
        endcase

        result.siren         = siren_next;
        result.alert_flag    = alert_next;
        result.resp_valid    = resp_valid;
        result.resp_code     = resp_valid ? resp_code : RESP_SILENCE;
        result.resp_dest     = resp_valid ? latched_source_next : 8'd0;
        result.resp_system   = resp_valid ? latched_system_next : 8'd0;
        result.resp_alert_id = resp_valid ? latched_id_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEBOUNCE_BITS-1:0];
                default:      timeout_reg  <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg       <= '0;
            last_sample_reg    <= '0;
            start_time_reg     <= '0;
            button_prev_reg    <= BUTTON_RELEASED;
            siren_reg          <= 1'b0;
            alert_reg          <= 1'b0;
            latched_id_reg     <= '0;
            latched_source_reg <= '0;
            latched_system_reg <= '0;
        end
        else if (step)
        begin
            time_now_reg       <= time_now_next;
            last_sample_reg    <= last_sample_next;
            start_time_reg     <= start_time_next;
            button_prev_reg    <= button_prev_next;
            siren_reg          <= siren_next;
            alert_reg          <= alert_next;
            latched_id_reg     <= latched_id_next;
            latched_source_reg <= latched_source_next;
            latched_system_reg <= latched_system_next;
        end
    end

endmodule

FILE: rtl/emergency_alert_siren_latch.sv
// top level of the alert latch and siren controller with input and result registers
//
//   port     | direction | handshake           | payload
//   in_data  | input     | in_valid / in_stall   | easl_pkg::in_item_t
//   out_data | output    | out_valid / out_stall | easl_pkg::out_item_t
//   cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// one item per cycle while out_stall does not hold a valid result; an accepted item is
// registered in the input register, then the state update writes it into the result register
// rst_n clears the valid flags and the core state and loads the register reset values
// out_stall holds the result register; the input register fills behind it
// and in_stall rises only once both are occupied
module emergency_alert_siren_latch #(
    parameter int TIME_BITS = easl_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [easl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [easl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  easl_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output easl_pkg::out_item_t                 out_data
);
    import easl_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t core_result;
    logic      advance;
    logic      accept;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    easl_core #(
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .step     (advance),
        .item     (in_data_reg),
        .result   (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: bench/emergency_alert_siren_latch_test.sv
// testbench for the alert latch and siren controller: directed and random items checked against a cycle-free model of the block
class alert_latch_tracker;
    logic [easl_pkg::CFG_DATA_BITS-1:0] timeout_ticks;
    logic [easl_pkg::DEBOUNCE_BITS-1:0] debounce_ticks;
    logic [31:0] time_now;
    logic [31:0] last_sample_time;
    logic [31:0] start_time;
    logic        button_prev;
    logic        siren_on;
    logic        alert_on;
    logic [15:0] latched_id;
    logic [7:0]  latched_source;
    logic [7:0]  latched_system;
    easl_pkg::out_item_t due_outcomes[$];
    int errors;

    function new();
        timeout_ticks = easl_pkg::TIMEOUT_RESET;
        debounce_ticks = easl_pkg::DEBOUNCE_RESET;
        time_now = '0;
        last_sample_time = '0;
        start_time = '0;
        button_prev = easl_pkg::BUTTON_RELEASED;
        siren_on = 1'b0;
        alert_on = 1'b0;
        latched_id = '0;
        latched_source = '0;
        latched_system = '0;
        errors = 0;
    endfunction

    function void write_register(logic [easl_pkg::CFG_INDEX_BITS-1:0] index,
                                 logic [easl_pkg::CFG_DATA_BITS-1:0] data);
        if (index == easl_pkg::CFG_TIMEOUT)
            timeout_ticks = data;
        else if (index == easl_pkg::CFG_DEBOUNCE)
            debounce_ticks = data[easl_pkg::DEBOUNCE_BITS-1:0];
    endfunction

    function bit outcomes_due();
        return due_outcomes.size() != 0;
    endfunction

    // next siren and alert state and the expected result for one accepted item
    function void note_item(easl_pkg::in_item_t item);
        easl_pkg::out_item_t outcome;
        logic        respond;
        logic        code;
        logic [15:0] id;
        logic [31:0] elapsed;
        respond = 1'b0;
        code = easl_pkg::RESP_SILENCE;
        id = {item.alert_id_high, item.alert_id_low};
        case (item.action)
            easl_pkg::ACT_FRAME:
            begin
                if (item.frame_length >= easl_pkg::MIN_FRAME_LEN
                        && item.type_byte[3:0] == easl_pkg::TYPE_EMERGENCY)
                begin
                    if (item.state_byte[3:0] <= easl_pkg::STATE_ACTIVE_MAX)
                    begin
                        latched_id = id;
                        latched_source = item.source_addr;
                        latched_system = item.system_byte;
                        alert_on = 1'b1;
                        if (!siren_on)
                            start_time = time_now;
                        siren_on = 1'b1;
                    end
                    else if (item.state_byte[3:0] >= easl_pkg::STATE_CLEAR_MIN && alert_on
                             && id == latched_id && item.source_addr == latched_source)
                    begin
                        alert_on = 1'b0;
                        siren_on = 1'b0;
                    end
                end
            end
            easl_pkg::ACT_TICK:
            begin
                time_now = time_now + 32'd1;
                elapsed = time_now - last_sample_time;
                if (elapsed >= {16'd0, debounce_ticks})
                begin
                    last_sample_time = time_now;
                    if (button_prev == easl_pkg::BUTTON_RELEASED
                            && item.button_level == easl_pkg::BUTTON_PRESSED && siren_on)
                    begin
                        respond = alert_on;
                        siren_on = 1'b0;
                    end
                    button_prev = item.button_level;
                end
                elapsed = time_now - start_time;
                if (siren_on && elapsed >= timeout_ticks)
                    siren_on = 1'b0;
            end
            easl_pkg::ACT_SILENCE:
            begin
                if (siren_on)
                begin
                    respond = alert_on;
                    siren_on = 1'b0;
                end
            end
            default:
            begin
                if (alert_on)
                begin
                    respond = 1'b1;
                    code = easl_pkg::RESP_ACK;
                    siren_on = 1'b0;
                    alert_on = 1'b0;
                end
            end
        endcase
        outcome = '0;
        outcome.siren = siren_on;
        outcome.alert_flag = alert_on;
        outcome.resp_valid = respond;
        if (respond)
        begin
            outcome.resp_code = code;
            outcome.resp_dest = latched_source;
            outcome.resp_system = latched_system;
            outcome.resp_alert_id = latched_id;
        end
        due_outcomes.push_back(outcome);
    endfunction

    function void flag_field(string field, logic [15:0] want, logic [15:0] seen);
        $display("%0t mismatch in %s: expected %0h actual %0h", $time, field, want, seen);
        errors++;
    endfunction

    function void check_result(easl_pkg::out_item_t seen);
        easl_pkg::out_item_t want;
        if (due_outcomes.size() == 0)
        begin
            $display("%0t unexpected item: expected none actual %h", $time, seen);
            errors++;
            return;
        end
        want = due_outcomes.pop_front();
        if (seen.siren !== want.siren)
            flag_field("siren", want.siren, seen.siren);
        if (seen.alert_flag !== want.alert_flag)
            flag_field("alert_flag", want.alert_flag, seen.alert_flag);
        if (seen.resp_valid !== want.resp_valid)
            flag_field("resp_valid", want.resp_valid, seen.resp_valid);
        if (seen.resp_code !== want.resp_code)
            flag_field("resp_code", want.resp_code, seen.resp_code);
        if (seen.resp_dest !== want.resp_dest)
            flag_field("resp_dest", want.resp_dest, seen.resp_dest);
        if (seen.resp_system !== want.resp_system)
            flag_field("resp_system", want.resp_system, seen.resp_system);
        if (seen.resp_alert_id !== want.resp_alert_id)
            flag_field("resp_alert_id", want.resp_alert_id, seen.resp_alert_id);
    endfunction
endclass

module emergency_alert_siren_latch_test;
    import easl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 170;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_item_t                 out_data;

    alert_latch_tracker tracker;
    int          cycles;
    int          calm_items;
    int          calm_results;
    logic        button_now;
    logic [15:0] last_alert_id;
    logic [7:0]  last_alert_src;

    emergency_alert_siren_latch dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    function automatic in_item_t frame_item(logic [3:0] len, logic [7:0] kind, logic [7:0] status,
                                            logic [15:0] id, logic [7:0] src, logic [7:0] sys);
        in_item_t item;
        item = '0;
        item.action = ACT_FRAME;
        item.frame_length = len;
        item.type_byte = kind;
        item.state_byte = status;
        {item.alert_id_high, item.alert_id_low} = id;
        item.source_addr = src;
        item.system_byte = sys;
        return item;
    endfunction

    function automatic in_item_t command_item(logic [1:0] act, logic level);
        in_item_t item;
        item = '0;
        item.action = act;
        item.button_level = level;
        return item;
    endfunction

    // mostly well-formed alert sequences, some noise
    function automatic in_item_t random_item();
        in_item_t    item;
        logic [63:0] noise;
        int          pick;
        int          mode;
        noise = {$urandom, $urandom};
        item = noise[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            item.action = ACT_TICK;
            if ($urandom_range(0, 5) == 0)
                button_now = ~button_now;
            item.button_level = button_now;
        end
        else if (pick < 75)
        begin
            item.action = ACT_FRAME;
            if ($urandom_range(0, 9) != 0)
            begin
                item.frame_length[3] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                    item.type_byte[3:0] = TYPE_EMERGENCY;
                else
                    item.type_byte[3:0] = 4'($urandom_range(1, 15));
                mode = $urandom_range(0, 9);
                if (mode < 4)
                begin
                    item.state_byte[3:0] = 4'($urandom_range(0, 2));
                    last_alert_id = {item.alert_id_high, item.alert_id_low};
                    last_alert_src = item.source_addr;
                end
                else if (mode < 8)
                begin
                    item.state_byte[3:0] = 4'($urandom_range(5, 15));
                    if (mode < 7)
                    begin
                        {item.alert_id_high, item.alert_id_low} = last_alert_id;
                        item.source_addr = last_alert_src;
                    end
                end
                else
                    item.state_byte[3:0] = 4'($urandom_range(3, 4));
            end
        end
        else if (pick < 88)
            item.action = ACT_SILENCE;
        else
            item.action = ACT_ACK;
        return item;
    endfunction

    task automatic run_item(input in_item_t item);
        int gap;
        if (calm_items > 0)
        begin
            gap = 0;
            calm_items--;
        end
        else
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0)
                calm_items = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(item);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outcomes_due())
            @(negedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_BITS-1:0] timeout,
                              input logic [DEBOUNCE_BITS-1:0] debounce);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= timeout;
        tracker.write_register(CFG_TIMEOUT, timeout);
        @(negedge clk);
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= {16'd0, debounce};
        tracker.write_register(CFG_DEBOUNCE, {16'd0, debounce});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // output side stalls
    initial
    begin
        int hold;
        out_stall = 1'b0;
        calm_results = 0;
        @(negedge clk);
        forever
        begin
            if (calm_results > 0)
            begin
                hold = 0;
                calm_results--;
            end
            else
            begin
                hold = $urandom_range(0, 6);
                if ($urandom_range(0, 29) == 0)
                    calm_results = $urandom_range(10, 40);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && rst_n))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        calm_items = 0;
        button_now = BUTTON_RELEASED;
        last_alert_id = '0;
        last_alert_src = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        run_item(frame_item(4'd0, 8'h00, 8'h00, 16'h1111, 8'h11, 8'h11));
        run_item(frame_item(4'd7, 8'h00, 8'h00, 16'h2222, 8'h22, 8'h22));
        run_item(command_item(ACT_SILENCE, BUTTON_RELEASED));
        run_item(command_item(ACT_ACK, BUTTON_RELEASED));
        run_item(frame_item(4'd8, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
        run_item(frame_item(4'd15, 8'hF0, 8'hF2, 16'hFFFF, 8'hFF, 8'hFF));
        run_item(frame_item(4'd8, 8'h01, 8'h00, 16'h3333, 8'h33, 8'h33));
        run_item(frame_item(4'd8, 8'h0F, 8'h00, 16'h4444, 8'h44, 8'h44));
        run_item(frame_item(4'd8, 8'h00, 8'h03, 16'h5555, 8'h55, 8'h55));
        run_item(frame_item(4'd8, 8'h00, 8'h04, 16'h6666, 8'h66, 8'h66));
        run_item(frame_item(4'd8, 8'h00, 8'h05, 16'h1234, 8'hFF, 8'h00));
        run_item(frame_item(4'd8, 8'h00, 8'h0F, 16'hFFFF, 8'hFF, 8'h00));
        run_item(frame_item(4'd9, 8'hA0, 8'h01, 16'hA55A, 8'h3C, 8'hC3));
        run_item(command_item(ACT_SILENCE, BUTTON_RELEASED));
        run_item(command_item(ACT_SILENCE, BUTTON_RELEASED));
        run_item(command_item(ACT_ACK, BUTTON_RELEASED));
        run_item(command_item(ACT_ACK, BUTTON_RELEASED));
        run_item(command_item(ACT_TICK, BUTTON_RELEASED));

        // button sampled on every tick, short safety timeout
        set_config(32'd3, 16'd0);
        run_item(frame_item(4'd8, 8'h00, 8'h00, 16'h0F0F, 8'h5A, 8'hA5));
        run_item(command_item(ACT_TICK, BUTTON_PRESSED));
        run_item(command_item(ACT_TICK, BUTTON_RELEASED));
        run_item(command_item(ACT_TICK, BUTTON_PRESSED));
        run_item(frame_item(4'd8, 8'h00, 8'h02, 16'hF0F0, 8'hA5, 8'h5A));
        repeat (3) run_item(command_item(ACT_TICK, BUTTON_RELEASED));

        // zero timeout
        set_config(32'd0, 16'hFFFF);
        run_item(frame_item(4'd8, 8'h00, 8'h00, 16'h8001, 8'h80, 8'h01));
        run_item(command_item(ACT_TICK, BUTTON_RELEASED));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(32'hFFFF_FFFF, 16'hFFFF);
                1: set_config(32'd0, 16'd0);
                2: set_config($urandom_range(1, 40), 16'($urandom_range(0, 3)));
                3: set_config(32'hFFFF_FFFF, 16'd0);
                4: set_config($urandom_range(0, 20), 16'd1);
                default: set_config($urandom_range(1, 40), 16'($urandom_range(0, 3)));
            endcase
            repeat (PHASE_ITEMS) run_item(random_item());
        end

        settle();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
